/* src/fcem_pkg.sv */
`timescale 1ns / 1ps

package fcem_pkg;

    // Table geometry
    localparam int TableEntries = 256;
    localparam int TableAddrW   = $clog2(TableEntries);

    // Configuration port geometry
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_QUOTE_MODE       = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_USE_FIRST_TABLE  = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_USE_SECOND_TABLE = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_NAME_CAPACITY    = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_CASE_RULE        = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_SEPARATOR_CHAR   = 3'd5;

    // Case folding rules
    localparam logic [1:0] CASE_NONE  = 2'd0;
    localparam logic [1:0] CASE_UPPER = 2'd1;
    localparam logic [1:0] CASE_WORD  = 2'd2;

    // Special bytes
    localparam logic [7:0] EscOpen   = 8'h9E;
    localparam logic [7:0] EscClose  = 8'h9F;
    localparam logic [7:0] SubstByte = 8'h5F;

    // Item operations, also used as the job kind between front and back
    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_NAME_BYTE   = 2'd2,
        OP_NAME_END    = 2'd3
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] table_index;
        logic [7:0] table_value;
        logic [7:0] name_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_name;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic        quote_mode;
        logic        use_first_table;
        logic        use_second_table;
        logic [15:0] name_capacity;
        logic [1:0]  case_rule;
        logic [7:0]  separator_char;
    } cfg_t;

    // Work handed from the front to the back
    typedef struct packed {
        op_t         kind;
        logic [7:0]  index;  // table entry for loads
        logic [7:0]  data;   // table value for loads, byte for name bytes
        logic        raw;    // decoded escape byte, skips the first table
        logic [15:0] cap;    // capacity sampled at the start of the name
    } job_t;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        return (b <= 8'h39) ? b[3:0] : b[3:0] + 4'd9;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
    endfunction

endpackage

/* src/fcem_ram.sv */
`timescale 1ns / 1ps

module fcem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port holding its data when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/fcem_queue.sv */
`timescale 1ns / 1ps

module fcem_queue
    import fcem_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    job_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/fcem_front.sv */
`timescale 1ns / 1ps

module fcem_front
    import fcem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     src_valid,
    output logic     src_ready,
    input  in_item_t src_item,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];
    logic [1:0]  held_cnt_reg, held_cnt_next;
    logic        flushing_reg, flushing_next;
    logic        in_name_reg, in_name_next;
    logic [15:0] name_cap_reg, name_cap_next;

    logic [7:0]  b;
    logic        mismatch;
    logic        flush_act;
    logic        start_hold;
    logic        accept;
    logic [7:0]  decoded;
    logic [15:0] job_cap;

    assign b          = src_item.name_byte;
    assign start_hold = !cfg.quote_mode && cfg.use_first_table && (b == EscOpen);
    assign decoded    = {hex_val(held_reg[1]), hex_val(held_reg[2])};
    assign job_cap    = in_name_reg ? name_cap_reg : cfg.name_capacity;

    // Classify: does the waiting item break the escape being collected
    always_comb
    begin
        mismatch = 1'b0;
        unique case (src_item.operation)
            OP_LOAD_FIRST, OP_LOAD_SECOND:
            begin
                mismatch = 1'b0;
            end
            OP_NAME_BYTE:
            begin
                unique case (held_cnt_reg)
                    2'd0:       mismatch = 1'b0;
                    2'd1, 2'd2: mismatch = !is_hex(b);
                    2'd3:       mismatch = (b != EscClose);
                endcase
            end
            OP_NAME_END:
            begin
                mismatch = (held_cnt_reg != 2'd0);
            end
        endcase
    end

    assign flush_act = flushing_reg || (src_valid && mismatch);
    assign accept    = src_valid && job_ready && !flush_act;

    // Flush held bytes first, then take the item and queue its job
    always_comb
    begin
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        flushing_next = flushing_reg;
        in_name_next  = in_name_reg;
        name_cap_next = name_cap_reg;
        src_ready     = 1'b0;
        job_valid     = 1'b0;
        job.kind      = OP_NAME_BYTE;
        job.index     = src_item.table_index;
        job.data      = held_reg[0];
        job.raw       = 1'b0;
        job.cap       = job_cap;

        if (flush_act)
        begin
            job_valid = 1'b1;
            if (job_ready)
            begin
                held_next[0]  = held_reg[1];
                held_next[1]  = held_reg[2];
                held_cnt_next = held_cnt_reg - 2'd1;
                flushing_next = (held_cnt_reg != 2'd1);
            end
            else
            begin
                flushing_next = 1'b1;
            end
        end
        else
        begin
            src_ready = job_ready;
            unique case (src_item.operation)
                OP_LOAD_FIRST, OP_LOAD_SECOND:
                begin
                    job_valid = src_valid;
                    job.kind  = src_item.operation;
                    job.data  = src_item.table_value;
                end
                OP_NAME_BYTE:
                begin
                    job.kind = OP_NAME_BYTE;
                    job.raw  = (held_cnt_reg == 2'd3);
                    job.data = (held_cnt_reg == 2'd3) ? decoded : b;
                    if (held_cnt_reg == 2'd0)
                    begin
                        job_valid = src_valid && !start_hold;
                    end
                    else if (held_cnt_reg == 2'd3)
                    begin
                        job_valid = src_valid;
                    end
                    if (accept)
                    begin
                        if (!in_name_reg)
                        begin
                            in_name_next  = 1'b1;
                            name_cap_next = cfg.name_capacity;
                        end
                        unique case (held_cnt_reg)
                            2'd0:
                            begin
                                if (start_hold)
                                begin
                                    held_next[0]  = b;
                                    held_cnt_next = 2'd1;
                                end
                            end
                            2'd1:
                            begin
                                held_next[1]  = b;
                                held_cnt_next = 2'd2;
                            end
                            2'd2:
                            begin
                                held_next[2]  = b;
                                held_cnt_next = 2'd3;
                            end
                            2'd3:
                            begin
                                held_cnt_next = 2'd0;
                            end
                        endcase
                    end
                end
                OP_NAME_END:
                begin
                    job_valid = src_valid;
                    job.kind  = OP_NAME_END;
                    if (accept)
                    begin
                        in_name_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            flushing_reg <= 1'b0;
            in_name_reg  <= 1'b0;
            held_reg[0]  <= 8'd0;
            held_reg[1]  <= 8'd0;
            held_reg[2]  <= 8'd0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            flushing_reg <= flushing_next;
            in_name_reg  <= in_name_next;
            held_reg     <= held_next;
        end
    end

    // Hold the capacity of the name in progress
    always_ff @(posedge clk)
    begin
        name_cap_reg <= name_cap_next;
    end

endmodule

/* src/fcem_back.sv */
`timescale 1ns / 1ps

module fcem_back
    import fcem_pkg::*;
#(
    parameter int CAPACITY_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    localparam logic [32:0] CapMax = (33'd1 << CAPACITY_BITS) - 33'd1;

    // Lookup pipeline
    logic                     adv;
    logic                     s1_valid_reg;
    job_t                     s1_job_reg;
    logic                     s2_valid_reg;
    op_t                      s2_kind_reg;
    logic [7:0]               s2_val_reg;
    logic [15:0]              s2_cap_reg;
    logic [7:0]               first_rd, second_rd;
    logic [7:0]               v1;

    // Name state
    logic                     in_name_reg, in_name_next;
    logic [CAPACITY_BITS-1:0] left_reg, left_next;
    logic                     ovf_reg, ovf_next;
    logic                     aws_reg, aws_next;
    logic [1:0]               sub_reg, sub_next;
    logic                     res_valid_reg, res_valid_next;
    out_item_t                res_item_reg, res_item_next;

    logic [CAPACITY_BITS-1:0] cap_sat, left_eff;
    logic                     esc, out_space, s2_done, emit;
    logic [7:0]               plain0, plain, esc_byte, pre_fold, folded;
    logic                     up, down;

    assign adv       = !s2_valid_reg || s2_done;
    assign job_ready = adv;
    assign v1        = (cfg.use_first_table && !s1_job_reg.raw) ? first_rd : s1_job_reg.data;

    fcem_ram #(
        .WIDTH(8),
        .DEPTH(TableEntries)
    ) u_first_table (
        .clk  (clk),
        .we   (job_valid && adv && (job.kind == OP_LOAD_FIRST)),
        .waddr(TableAddrW'(job.index)),
        .wdata(job.data),
        .re   (adv),
        .raddr(TableAddrW'(job.data)),
        .rdata(first_rd)
    );

    fcem_ram #(
        .WIDTH(8),
        .DEPTH(TableEntries)
    ) u_second_table (
        .clk  (clk),
        .we   (job_valid && adv && (job.kind == OP_LOAD_SECOND)),
        .waddr(TableAddrW'(job.index)),
        .wdata(job.data),
        .re   (adv),
        .raddr(TableAddrW'(v1)),
        .rdata(second_rd)
    );

    // Saturate capacity and pick up the counter at the first job of a name
    assign cap_sat  = ({17'd0, s2_cap_reg} > CapMax) ? CapMax[CAPACITY_BITS-1:0]
                                                      : CAPACITY_BITS'(s2_cap_reg);
    assign left_eff = in_name_reg ? left_reg : cap_sat;

    // Decide between plain byte and four-byte escape
    assign esc    = cfg.use_second_table && cfg.quote_mode &&
                    ((second_rd == 8'd0) || (second_rd == EscOpen) || (second_rd == EscClose));
    assign plain0 = cfg.use_second_table ? second_rd : s2_val_reg;
    assign plain  = (plain0 == 8'd0) ? SubstByte : plain0;

    always_comb
    begin
        unique case (sub_reg)
            2'd0: esc_byte = EscOpen;
            2'd1: esc_byte = hex_char(s2_val_reg[7:4]);
            2'd2: esc_byte = hex_char(s2_val_reg[3:0]);
            2'd3: esc_byte = EscClose;
        endcase
    end

    // Fold case of the outgoing byte
    assign pre_fold = esc ? esc_byte : plain;
    assign up       = (cfg.case_rule == CASE_UPPER) || ((cfg.case_rule == CASE_WORD) && aws_reg);
    assign down     = (cfg.case_rule == CASE_WORD) && !aws_reg;

    always_comb
    begin
        folded = pre_fold;
        if (up && pre_fold >= 8'h61 && pre_fold <= 8'h7A)
        begin
            folded = pre_fold - 8'h20;
        end
        else if (down && pre_fold >= 8'h41 && pre_fold <= 8'h5A)
        begin
            folded = pre_fold + 8'h20;
        end
    end

    assign out_space = !res_valid_reg || res_ready;

    // Emit results of the job in the last stage
    always_comb
    begin
        in_name_next  = in_name_reg;
        left_next     = left_reg;
        ovf_next      = ovf_reg;
        aws_next      = aws_reg;
        sub_next      = sub_reg;
        s2_done       = 1'b0;
        emit          = 1'b0;
        res_item_next = res_item_reg;

        if (s2_valid_reg)
        begin
            unique case (s2_kind_reg)
                OP_LOAD_FIRST, OP_LOAD_SECOND:
                begin
                    s2_done = 1'b1;
                end
                OP_NAME_BYTE:
                begin
                    in_name_next = 1'b1;
                    left_next    = left_eff;
                    if (ovf_reg)
                    begin
                        s2_done = 1'b1;
                    end
                    else if (esc)
                    begin
                        if (sub_reg == 2'd0 && left_eff < CAPACITY_BITS'(4))
                        begin
                            ovf_next = 1'b1;
                            s2_done  = 1'b1;
                        end
                        else if (out_space)
                        begin
                            emit     = 1'b1;
                            sub_next = sub_reg + 2'd1;
                            s2_done  = (sub_reg == 2'd3);
                            if (sub_reg == 2'd0)
                            begin
                                left_next = left_eff - CAPACITY_BITS'(4);
                            end
                        end
                    end
                    else if (left_eff == '0)
                    begin
                        ovf_next = 1'b1;
                        s2_done  = 1'b1;
                    end
                    else if (out_space)
                    begin
                        emit      = 1'b1;
                        s2_done   = 1'b1;
                        left_next = left_eff - CAPACITY_BITS'(1);
                    end
                    if (emit)
                    begin
                        res_item_next.out_byte    = folded;
                        res_item_next.end_of_name = 1'b0;
                        res_item_next.status      = 1'b0;
                        aws_next                  = (folded == cfg.separator_char);
                    end
                end
                OP_NAME_END:
                begin
                    if (out_space)
                    begin
                        emit                      = 1'b1;
                        s2_done                   = 1'b1;
                        res_item_next.out_byte    = 8'd0;
                        res_item_next.end_of_name = 1'b1;
                        res_item_next.status      = ovf_reg || (left_eff == '0);
                        ovf_next                  = 1'b0;
                        aws_next                  = 1'b1;
                        in_name_next              = 1'b0;
                    end
                end
            endcase
        end

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            in_name_reg   <= 1'b0;
            left_reg      <= '0;
            ovf_reg       <= 1'b0;
            aws_reg       <= 1'b1;
            sub_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= job_valid;
                s2_valid_reg <= s1_valid_reg;
            end
            in_name_reg   <= in_name_next;
            left_reg      <= left_next;
            ovf_reg       <= ovf_next;
            aws_reg       <= aws_next;
            sub_reg       <= sub_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Advance payload through the lookup stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_job_reg  <= job;
            s2_kind_reg <= s1_job_reg.kind;
            s2_val_reg  <= v1;
            s2_cap_reg  <= s1_job_reg.cap;
        end
        res_item_reg <= res_item_next;
    end

endmodule

/* src/filename_charset_escape_mapper.sv */
`timescale 1ns / 1ps

// Filename byte mapper with escape handling.
// Input channel src_*: one item per transfer; table loads, name bytes and
// the end of a name. Result channel res_*: one converted byte per transfer,
// the last result of a name carries end_of_name and the overflow status.
// Configuration channel cfg_*: always ready, one register per transfer; write
// it only while no name byte is in flight.
// Each accepted item passes the queue, the first table read, the second
// table read and the output register before its result appears.
// Throughput: while results are taken, one item per cycle for plain bytes
// and loads; an escaped byte holds the emit stage for its four result bytes,
// which is the output rate limit. Held escape bytes that do not form an escape
// are replayed one per cycle while the queue has room, then the item is taken.
// Reset clears the control state and the configuration to its defaults; the
// translation tables hold nothing defined until loaded.
// When the receiver stalls, the output register holds its result, the emit
// stage stops, and the job queue absorbs up to QUEUE_DEPTH items before
// src_ready drops.
module filename_charset_escape_mapper
    import fcem_pkg::*;
#(
    parameter int CAPACITY_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  in_item_t             src_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_item_t            res_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic front_valid, front_ready;
    job_t front_job;
    logic back_valid, back_ready;
    job_t back_job;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quote_mode       <= 1'b0;
            cfg_reg.use_first_table  <= 1'b1;
            cfg_reg.use_second_table <= 1'b0;
            cfg_reg.name_capacity    <= 16'd256;
            cfg_reg.case_rule        <= CASE_NONE;
            cfg_reg.separator_char   <= 8'd46;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_QUOTE_MODE:       cfg_reg.quote_mode       <= cfg_data[0];
                CFG_USE_FIRST_TABLE:  cfg_reg.use_first_table  <= cfg_data[0];
                CFG_USE_SECOND_TABLE: cfg_reg.use_second_table <= cfg_data[0];
                CFG_NAME_CAPACITY:    cfg_reg.name_capacity    <= cfg_data;
                CFG_CASE_RULE:        cfg_reg.case_rule        <= cfg_data[1:0];
                CFG_SEPARATOR_CHAR:   cfg_reg.separator_char   <= cfg_data[7:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    fcem_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .src_valid(src_valid),
        .src_ready(src_ready),
        .src_item (src_item),
        .job_valid(front_valid),
        .job_ready(front_ready),
        .job      (front_job)
    );

    fcem_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(front_valid),
        .push_ready(front_ready),
        .push_job  (front_job),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_job   (back_job)
    );

    fcem_back #(
        .CAPACITY_BITS(CAPACITY_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .job_valid(back_valid),
        .job_ready(back_ready),
        .job      (back_job),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_item (res_item)
    );

endmodule
